@@ sv/sem_pkg.sv @@
// Package for the Sobel edge magnitude block: sizes, register indexes, pixel type.
// No dependencies.
package sem_pkg;

    localparam int MaxWidthDef  = 1024;
    localparam int MaxHeightDef = 4096;
    localparam int PixW         = 24;
    localparam int CfgIdxW      = 1;

    localparam logic [CfgIdxW-1:0] RegWidth  = 1'b0;
    localparam logic [CfgIdxW-1:0] RegHeight = 1'b1;

    localparam logic KindPixel = 1'b0;
    localparam logic KindDrain = 1'b1;

    // Sum of squares fits in 22 bits (max 2080800).
    localparam int SqW   = 22;
    localparam int RootW = 11;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } pix_t;

endpackage

@@ sv/sem_ram.sv @@
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
module sem_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ sv/sem_mag.sv @@
// One channel's Sobel magnitude: gradients, squares, bit-serial root, rounding.
// Depends on sem_pkg. Phases: gradients, sum of squares, root steps, rounding.
module sem_mag (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       start,
    input  logic [7:0] t0, t1, t2, t3, t5, t6, t7, t8,
    output logic       done,
    output logic [7:0] mag
);
    logic signed [10:0] gx_reg, gy_reg;
    logic [sem_pkg::SqW-1:0] s_reg, rem_reg, s_next;
    logic [sem_pkg::RootW-1:0] root_reg;
    logic [3:0] step_reg;
    logic [1:0] ph_reg;
    logic [10:0] ax, ay;
    logic [sem_pkg::SqW+1:0] trial;
    logic [sem_pkg::SqW+1:0] remsh;

    always_comb begin
        ax = gx_reg[10] ? 11'(-gx_reg) : 11'(gx_reg);
        ay = gy_reg[10] ? 11'(-gy_reg) : 11'(gy_reg);
        s_next = ({11'b0, ax} * {11'b0, ax}) + ({11'b0, ay} * {11'b0, ay});
        remsh = {rem_reg, s_reg[sem_pkg::SqW-1 -: 2]};
        trial = {root_reg, 2'b01};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ph_reg <= '0;
            done <= 1'b0;
        end else begin
            done <= 1'b0;
            unique case (ph_reg)
                2'd0: if (start) begin
                    gx_reg <= 11'($signed({3'b0, t6}) + $signed({2'b0, t7, 1'b0})
                        + $signed({3'b0, t8}) - $signed({3'b0, t0})
                        - $signed({2'b0, t1, 1'b0}) - $signed({3'b0, t2}));
                    gy_reg <= 11'($signed({3'b0, t2}) + $signed({2'b0, t5, 1'b0})
                        + $signed({3'b0, t8}) - $signed({3'b0, t0})
                        - $signed({2'b0, t3, 1'b0}) - $signed({3'b0, t6}));
                    ph_reg <= 2'd1;
                end
                2'd1: begin
                    s_reg <= s_next;
                    rem_reg <= '0;
                    root_reg <= '0;
                    step_reg <= '0;
                    ph_reg <= 2'd2;
                end
                2'd2: begin
                    if (remsh >= trial) begin
                        rem_reg <= sem_pkg::SqW'(remsh - trial);
                        root_reg <= {root_reg[sem_pkg::RootW-2:0], 1'b1};
                    end else begin
                        rem_reg <= sem_pkg::SqW'(remsh);
                        root_reg <= {root_reg[sem_pkg::RootW-2:0], 1'b0};
                    end
                    s_reg <= {s_reg[sem_pkg::SqW-3:0], 2'b00};
                    step_reg <= step_reg + 4'd1;
                    if (step_reg == 4'(sem_pkg::RootW - 1)) ph_reg <= 2'd3;
                end
                2'd3: begin
                    // remainder = s - q*q; round up when it exceeds q
                    if ({1'b0, root_reg} + ((rem_reg > sem_pkg::SqW'(root_reg)) ? 12'd1 : 12'd0)
                        > 12'd255)
                        mag <= 8'd255;
                    else
                        mag <= 8'(root_reg + ((rem_reg > sem_pkg::SqW'(root_reg)) ? 1 : 0));
                    done <= 1'b1;
                    ph_reg <= 2'd0;
                end
                default: ph_reg <= 2'd0;
            endcase
        end
    end
endmodule

@@ sv/sobel_edge_magnitude_rgb_top.sv @@
// Sobel edge magnitude over RGB, 3x3 window, zero outside the image.
// A transfer in that releases no result passes accept, line-store read and window
// update; one that releases a result adds the magnitude (11-step bit-serial root,
// channels in parallel) and an output load that waits while the previous result is
// unaccepted. No new input is taken until the last one is through. Output k leaves with input k+W+1.
// aresetn (sync, low) clears counters and window and sets sizes to 640x480; line stores are not cleared.
module sobel_edge_magnitude_rgb_top #(
    parameter int MAX_WIDTH  = sem_pkg::MaxWidthDef,
    parameter int MAX_HEIGHT = sem_pkg::MaxHeightDef
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // red_in, green_in, blue_in
    input  logic        s_tuser,   // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // red_edge, green_edge, blue_edge
    output logic        m_tlast,   // last_pixel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [sem_pkg::CfgIdxW-1:0] cfg_index,
    input  logic [12:0] cfg_data
);
    localparam int AW = $clog2(MAX_WIDTH);
    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 1);
    localparam int PW = CW + RW;

    typedef enum logic [2:0] {S_IDLE, S_READ, S_WIN, S_MAG, S_OUT} state_t;
    state_t state_reg;

    logic [10:0] width_reg;
    logic [12:0] height_reg;
    logic [CW-1:0] w_eff;
    logic [RW-1:0] h_eff;
    logic [CW-1:0] in_col_reg, out_col_reg;
    logic [RW-1:0] in_row_reg, out_row_reg;
    logic [sem_pkg::PixW-1:0] win_reg [6];
    logic [sem_pkg::PixW-1:0] pix_reg, top_q, mid_q;
    logic [sem_pkg::PixW-1:0] tap [9];
    logic [sem_pkg::PixW-1:0] top_reg, mid_reg;
    logic last_reg;
    logic [AW-1:0] addr;
    logic we;
    logic [2:0] mdone, mdone_reg;
    logic [7:0] mag [3];
    logic start_reg;
    logic [PW-1:0] pos;
    logic emit;
    logic out_load, last_now, m_tvalid_next;

    always_comb begin
        if (width_reg == 11'd0) w_eff = CW'(1);
        else if ({21'b0, width_reg} > MAX_WIDTH) w_eff = CW'(MAX_WIDTH);
        else w_eff = CW'(width_reg);
        if (height_reg == 13'd0) h_eff = RW'(1);
        else if ({19'b0, height_reg} > MAX_HEIGHT) h_eff = RW'(MAX_HEIGHT);
        else h_eff = RW'(height_reg);
    end

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE) && !s_tvalid && !m_tvalid;
    assign addr = (in_col_reg < CW'(MAX_WIDTH)) ? AW'(in_col_reg) : '0;
    assign we = (state_reg == S_READ);
    assign pos = PW'(in_row_reg) * PW'(w_eff) + PW'(in_col_reg);
    assign emit = pos >= PW'(w_eff) + PW'(1);
    assign out_load = (state_reg == S_OUT) && (!m_tvalid || m_tready);
    assign last_now = (out_row_reg == h_eff - 1'b1) && (out_col_reg == w_eff - 1'b1);
    assign m_tvalid_next = out_load || (m_tvalid && !m_tready);

    sem_ram #(.WIDTH(sem_pkg::PixW), .DEPTH(MAX_WIDTH)) u_upper (
        .aclk(aclk), .we(we), .waddr(addr), .wdata(mid_q), .raddr(addr), .rdata(top_q));
    sem_ram #(.WIDTH(sem_pkg::PixW), .DEPTH(MAX_WIDTH)) u_middle (
        .aclk(aclk), .we(we), .waddr(addr), .wdata(pix_reg), .raddr(addr), .rdata(mid_q));

    always_comb begin
        tap[0] = win_reg[0]; tap[1] = win_reg[1]; tap[2] = win_reg[2];
        tap[3] = win_reg[3]; tap[4] = win_reg[4]; tap[5] = win_reg[5];
        tap[6] = top_reg;    tap[7] = mid_reg;    tap[8] = pix_reg;
        for (int c = 0; c < 3; c++) begin
            if (out_row_reg == '0) tap[c*3] = '0;
            if ({1'b0, out_row_reg} + 1 >= {1'b0, h_eff}) tap[c*3+2] = '0;
        end
        for (int r = 0; r < 3; r++) begin
            if (out_col_reg == '0) tap[r] = '0;
            if ({1'b0, out_col_reg} + 1 >= {1'b0, w_eff}) tap[6+r] = '0;
        end
    end

    for (genvar ch = 0; ch < 3; ch++) begin : g_ch
        localparam int SH = 8*ch;
        sem_mag u_mag (
            .aclk(aclk), .aresetn(aresetn), .start(start_reg),
            .t0(tap[0][SH+:8]), .t1(tap[1][SH+:8]), .t2(tap[2][SH+:8]),
            .t3(tap[3][SH+:8]), .t5(tap[5][SH+:8]), .t6(tap[6][SH+:8]),
            .t7(tap[7][SH+:8]), .t8(tap[8][SH+:8]),
            .done(mdone[ch]), .mag(mag[ch]));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            width_reg <= 11'd640;
            height_reg <= 13'd480;
            in_col_reg <= '0; in_row_reg <= '0;
            out_col_reg <= '0; out_row_reg <= '0;
            for (int i = 0; i < 6; i++) win_reg[i] <= '0;
            m_tvalid <= 1'b0;
            start_reg <= 1'b0;
            mdone_reg <= '0;
        end else begin
            start_reg <= 1'b0;
            m_tvalid <= m_tvalid_next;
            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        if (s_tuser == sem_pkg::KindDrain && in_row_reg == '0
                            && in_col_reg == '0) begin
                            state_reg <= S_IDLE;
                        end else begin
                            pix_reg <= (s_tuser == sem_pkg::KindPixel && in_row_reg < h_eff)
                                ? s_tdata : '0;
                            state_reg <= S_READ;
                        end
                    end else if (cfg_valid) begin
                        if (cfg_index == sem_pkg::RegWidth) width_reg <= cfg_data[10:0];
                        else height_reg <= cfg_data;
                        in_col_reg <= '0; in_row_reg <= '0;
                        out_col_reg <= '0; out_row_reg <= '0;
                        for (int i = 0; i < 6; i++) win_reg[i] <= '0;
                    end
                end
                S_READ: state_reg <= S_WIN;
                S_WIN: begin
                    top_reg <= top_q;
                    mid_reg <= mid_q;
                    if (emit) begin
                        state_reg <= S_MAG;
                        start_reg <= 1'b1;
                    end else begin
                        win_reg[0] <= win_reg[3]; win_reg[1] <= win_reg[4];
                        win_reg[2] <= win_reg[5]; win_reg[3] <= top_q;
                        win_reg[4] <= mid_q;      win_reg[5] <= pix_reg;
                        if (in_col_reg + 1'b1 >= w_eff) begin
                            in_col_reg <= '0; in_row_reg <= in_row_reg + 1'b1;
                        end else in_col_reg <= in_col_reg + 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                S_MAG: begin
                    if (mdone[0]) begin
                        mdone_reg <= mdone;
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: begin
                    // load the output register once the previous transfer has left
                    if (out_load) begin
                        m_tdata <= {mag[2], mag[1], mag[0]};
                        last_reg <= last_now;
                        state_reg <= S_IDLE;
                        if (last_now) begin
                            in_col_reg <= '0; in_row_reg <= '0;
                            out_col_reg <= '0; out_row_reg <= '0;
                            for (int i = 0; i < 6; i++) win_reg[i] <= '0;
                        end else begin
                            win_reg[0] <= win_reg[3]; win_reg[1] <= win_reg[4];
                            win_reg[2] <= win_reg[5]; win_reg[3] <= top_reg;
                            win_reg[4] <= mid_reg;    win_reg[5] <= pix_reg;
                            if (in_col_reg + 1'b1 >= w_eff) begin
                                in_col_reg <= '0; in_row_reg <= in_row_reg + 1'b1;
                            end else in_col_reg <= in_col_reg + 1'b1;
                            if (out_col_reg + 1'b1 >= w_eff) begin
                                out_col_reg <= '0; out_row_reg <= out_row_reg + 1'b1;
                            end else out_col_reg <= out_col_reg + 1'b1;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tlast = last_reg;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output transfer changed while waiting");
    a_ch_sync: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT) |-> mdone_reg == 3'b111) else $error("channels out of step");
    a_col_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        in_col_reg < w_eff || $past(cfg_valid && cfg_ready)) else $error("column overrun");
endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for sobel_edge_magnitude_rgb_top: random RGB images over
// many sizes, with a scoreboard class that predicts every edge-magnitude transfer.
// Depends on sem_pkg and the block's RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WatchLimit = 3000;
    localparam int SettleCycles = 40;

    typedef struct {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic       last;
    } edge_t;

    class edge_scoreboard;
        sem_pkg::pix_t upper[sem_pkg::MaxWidthDef];
        sem_pkg::pix_t middle[sem_pkg::MaxWidthDef];
        sem_pkg::pix_t win_cols[6];
        int unsigned in_row, in_col, out_row, out_col;
        int unsigned width_reg, height_reg;
        edge_t       edge_q[$];
        int          errors;

        function new();
            foreach (upper[i]) begin
                upper[i] = '0;
                middle[i] = '0;
            end
            width_reg = 640;
            height_reg = 480;
            errors = 0;
            clear_stream();
        endfunction

        function void clear_stream();
            in_row = 0;
            in_col = 0;
            out_row = 0;
            out_col = 0;
            foreach (win_cols[i]) win_cols[i] = '0;
        endfunction

        function int unsigned clamp_size(int unsigned v, int unsigned maxv);
            if (v == 0) return 1;
            if (v > maxv) return maxv;
            return v;
        endfunction

        function void set_reg(logic [sem_pkg::CfgIdxW-1:0] idx, logic [12:0] val);
            if (idx == sem_pkg::RegWidth) width_reg = val[10:0];
            else height_reg = val;
            clear_stream();
        endfunction

        function logic [7:0] magnitude(int t[9]);
            int gx, gy, s, q, cand;
            gx = -t[0] - 2 * t[1] - t[2] + t[6] + 2 * t[7] + t[8];
            gy = -t[0] - 2 * t[3] - t[6] + t[2] + 2 * t[5] + t[8];
            s = gx * gx + gy * gy;
            q = 0;
            for (int b = 10; b >= 0; b--) begin
                cand = q | (1 << b);
                if (cand * cand <= s) q = cand;
            end
            if (s > q * q + q) q++;
            return (q > 255) ? 8'd255 : q[7:0];
        endfunction

        // One accepted input transfer; queues the result it releases, if any.
        function void note_input(logic kind, logic [23:0] data);
            int unsigned w, h, c;
            longint unsigned pos;
            sem_pkg::pix_t pix, top, mid;
            sem_pkg::pix_t taps[9];
            int tr[9], tg[9], tb[9];
            bit emit, ok;
            edge_t e;
            w = clamp_size(width_reg, sem_pkg::MaxWidthDef);
            h = clamp_size(height_reg, sem_pkg::MaxHeightDef);
            if (kind == sem_pkg::KindDrain && in_row == 0 && in_col == 0) return;
            pix = '0;
            if (kind == sem_pkg::KindPixel && in_row < h) begin
                pix.r = data[7:0];
                pix.g = data[15:8];
                pix.b = data[23:16];
            end
            c = in_col;
            top = upper[c];
            mid = middle[c];
            upper[c] = mid;
            middle[c] = pix;
            pos = longint'(in_row) * w + in_col;
            emit = pos >= w + 1;
            if (emit) begin
                for (int i = 0; i < 6; i++) taps[i] = win_cols[i];
                taps[6] = top;
                taps[7] = mid;
                taps[8] = pix;
                for (int col = 0; col < 3; col++) begin
                    for (int row = 0; row < 3; row++) begin
                        ok = 1;
                        if (row == 0 && out_row == 0) ok = 0;
                        if (row == 2 && out_row + 1 >= h) ok = 0;
                        if (col == 0 && out_col == 0) ok = 0;
                        if (col == 2 && out_col + 1 >= w) ok = 0;
                        if (!ok) taps[col * 3 + row] = '0;
                    end
                end
                for (int i = 0; i < 9; i++) begin
                    tr[i] = taps[i].r;
                    tg[i] = taps[i].g;
                    tb[i] = taps[i].b;
                end
                e.r = magnitude(tr);
                e.g = magnitude(tg);
                e.b = magnitude(tb);
                e.last = (out_row == h - 1 && out_col == w - 1);
                edge_q.push_back(e);
            end
            win_cols[0] = win_cols[3];
            win_cols[1] = win_cols[4];
            win_cols[2] = win_cols[5];
            win_cols[3] = top;
            win_cols[4] = mid;
            win_cols[5] = pix;
            in_col++;
            if (in_col >= w) begin
                in_col = 0;
                in_row++;
            end
            if (emit) begin
                if (e.last) begin
                    clear_stream();
                end else begin
                    out_col++;
                    if (out_col >= w) begin
                        out_col = 0;
                        out_row++;
                    end
                end
            end
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 40) $display("mismatch: %s", msg);
        endtask

        task check_result(logic [23:0] data, logic last);
            edge_t e;
            if (edge_q.size() == 0) begin
                report($sformatf("unexpected transfer data=%h last=%b", data, last));
                return;
            end
            e = edge_q.pop_front();
            if (data[7:0] !== e.r)
                report($sformatf("red got %0d want %0d", data[7:0], e.r));
            if (data[15:8] !== e.g)
                report($sformatf("green got %0d want %0d", data[15:8], e.g));
            if (data[23:16] !== e.b)
                report($sformatf("blue got %0d want %0d", data[23:16], e.b));
            if (last !== e.last)
                report($sformatf("last got %b want %b", last, e.last));
        endtask
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid, s_tready, s_tuser;
    logic [23:0] s_tdata;
    logic        m_tvalid, m_tready, m_tlast;
    logic [23:0] m_tdata;
    logic        cfg_valid, cfg_ready;
    logic [sem_pkg::CfgIdxW-1:0] cfg_index;
    logic [12:0] cfg_data;

    edge_scoreboard sb = new();
    bit  offering = 0;
    bit  pressure_done = 0;
    int  cyc = 0;
    int  results_seen = 0;
    int  quiet_cycles = 0;
    int  fed = 0;

    sobel_edge_magnitude_rgb_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    function bit no_idle_window();
        return cyc >= 8000 && cyc < 14000;
    endfunction

    always @(posedge aclk) begin
        cyc <= cyc + 1;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) sb.set_reg(cfg_index, cfg_data);
            if (s_tvalid && s_tready) sb.note_input(s_tuser, s_tdata);
            if (m_tvalid && m_tready) begin
                sb.check_result(m_tdata, m_tlast);
                results_seen++;
            end
            if ((cfg_valid && cfg_ready) || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WatchLimit) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial begin
        m_tready = 0;
        @(posedge aclk iff aresetn);
        forever begin
            @(posedge aclk);
            if (!pressure_done && results_seen >= 100) begin
                pressure_done = 1;
                m_tready <= 0;
                repeat (500) @(posedge aclk);
            end else begin
                m_tready <= no_idle_window() || ($urandom_range(0, 99) >= 30);
            end
        end
    end

    task send(logic kind, logic [23:0] data);
        s_tvalid <= 1;
        s_tuser <= kind;
        s_tdata <= data;
        offering = 1;
        fed++;
        do @(posedge aclk); while (!s_tready);
        if (!no_idle_window() && $urandom_range(0, 99) < 30) begin
            s_tvalid <= 0;
            offering = 0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
    endtask

    task wait_idle();
        if (offering) begin
            s_tvalid <= 0;
            offering = 0;
        end
        do @(posedge aclk); while (sb.edge_q.size() != 0);
        repeat (SettleCycles) @(posedge aclk);
    endtask

    task write_cfg(bit do_w, bit do_h, logic [12:0] w, logic [12:0] h);
        wait_idle();
        if (do_w) begin
            cfg_valid <= 1;
            cfg_index <= sem_pkg::RegWidth;
            cfg_data <= w;
            do @(posedge aclk); while (!cfg_ready);
        end
        if (do_h) begin
            cfg_valid <= 1;
            cfg_index <= sem_pkg::RegHeight;
            cfg_data <= h;
            do @(posedge aclk); while (!cfg_ready);
        end
        cfg_valid <= 0;
    endtask

    // One image (or part of one) of random pixels and drains, then, if with_tail, the flush tail.
    task run_image(int unsigned w, int unsigned h, int unsigned n_pix, bit with_tail);
        for (int unsigned i = 0; i < n_pix; i++) begin
            if ($urandom_range(0, 99) < 8) send(sem_pkg::KindDrain, 24'($urandom()));
            else send(sem_pkg::KindPixel, 24'($urandom()));
        end
        if (with_tail) begin
            for (int unsigned i = 0; i <= w; i++) begin
                if ($urandom_range(0, 99) < 25) send(sem_pkg::KindPixel, 24'($urandom()));
                else send(sem_pkg::KindDrain, 24'($urandom()));
            end
        end
    endtask

    initial begin
        int unsigned w, h, wr_w, wr_h;
        bit need_cfg;
        aresetn = 0;
        s_tvalid = 0;
        s_tuser = 0;
        s_tdata = '0;
        cfg_valid = 0;
        cfg_index = sem_pkg::RegWidth;
        cfg_data = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // drain with no image in progress is dropped
        send(sem_pkg::KindDrain, 24'hffffff);
        wait_idle();
        // single-pixel image
        write_cfg(1, 1, 13'd1, 13'd1);
        send(sem_pkg::KindPixel, 24'hffffff);
        send(sem_pkg::KindDrain, 24'h0);
        send(sem_pkg::KindDrain, 24'h0);
        wait_idle();
        // zero sizes act as one; pixel after image complete acts as drain
        write_cfg(1, 1, 13'd0, 13'd0);
        send(sem_pkg::KindPixel, 24'h563412);
        send(sem_pkg::KindDrain, 24'h0);
        send(sem_pkg::KindPixel, 24'hffffff);
        wait_idle();
        // 3x3 checkerboard with one drain mid-image
        write_cfg(1, 1, 13'd3, 13'd3);
        for (int i = 0; i < 9; i++) begin
            if (i == 4) send(sem_pkg::KindDrain, 24'hffffff);
            else send(sem_pkg::KindPixel, (i % 2) ? 24'hffffff : 24'h000000);
        end
        for (int i = 0; i < 4; i++) send(sem_pkg::KindDrain, 24'h0);
        wait_idle();

        // largest sizes, partial images
        write_cfg(1, 1, 13'd2047, 13'd3);
        run_image(1024, 3, 1030, 0);
        wait_idle();
        write_cfg(1, 1, 13'd1, 13'd8191);
        run_image(1, 4096, 10, 0);
        wait_idle();

        need_cfg = 1;
        w = 1;
        h = 1;
        while (fed < 1800) begin
            if (need_cfg || $urandom_range(0, 99) < 80) begin
                wr_w = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 8) : $urandom_range(9, 40);
                wr_h = $urandom_range(0, 8);
                case ($urandom_range(0, 5))
                    0: begin
                        write_cfg(1, 0, 13'(wr_w), 13'd0);
                        w = sb.clamp_size(wr_w, sem_pkg::MaxWidthDef);
                    end
                    1: begin
                        write_cfg(0, 1, 13'd0, 13'(wr_h));
                        h = sb.clamp_size(wr_h, sem_pkg::MaxHeightDef);
                    end
                    default: begin
                        write_cfg(1, 1, 13'(wr_w), 13'(wr_h));
                        w = sb.clamp_size(wr_w, sem_pkg::MaxWidthDef);
                        h = sb.clamp_size(wr_h, sem_pkg::MaxHeightDef);
                    end
                endcase
            end
            if ($urandom_range(0, 99) < 20) send(sem_pkg::KindDrain, 24'($urandom()));
            if ($urandom_range(0, 99) < 10) begin
                run_image(w, h, $urandom_range(0, w * h), 0);
                need_cfg = 1;
                wait_idle();
            end else begin
                run_image(w, h, w * h, 1);
                need_cfg = 0;
                if ($urandom_range(0, 99) < 70) wait_idle();
            end
        end
        wait_idle();

        while (sb.edge_q.size() != 0) begin
            void'(sb.edge_q.pop_front());
            sb.report("expected transfer never arrived");
        end
        if (sb.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

@@ sim.f @@
sv/sem_pkg.sv
sv/sem_ram.sv
sv/sem_mag.sv
sv/sobel_edge_magnitude_rgb_top.sv
tb/testbench.sv
